@@ rtl/vefm_pkg.sv @@
// Shared types, constants and helpers for the voxel exposed face mask block.
package vefm_pkg;

  localparam int unsigned MAX_X   = 32;
  localparam int unsigned MAX_Y   = 32;
  localparam int unsigned MAX_Z   = 32;
  localparam int unsigned COORD_W = 5;
  localparam int unsigned SIZE_W  = 6;
  localparam int unsigned FACE_W  = 6;
  localparam int unsigned NUM_NBR = 6;
  localparam int unsigned NBR_W   = 3;
  localparam int unsigned CELLS   = MAX_X * MAX_Y * MAX_Z;
  localparam int unsigned ADDR_W  = $clog2(CELLS);
  localparam int unsigned WORD_W  = FACE_W + 1;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  localparam logic [FACE_W-1:0] ALL_FACES = 6'h3f;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [COORD_W-1:0] z_coord;
  } vefm_in_t;

  typedef struct packed {
    logic              in_range;
    logic              occupied;
    logic [FACE_W-1:0] face_mask;
    logic              visible;
  } vefm_out_t;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               in_range;
    logic [NUM_NBR-1:0] nbr_ok;
  } vefm_cmd_t;

  // Neighbor order: -x, +x, -y, +y, -z, +z.
  function automatic logic [FACE_W-1:0] own_bit(logic [NBR_W-1:0] k);
    return FACE_W'(6'b100000 >> k);
  endfunction

  function automatic logic [FACE_W-1:0] their_bit(logic [NBR_W-1:0] k);
    return own_bit(k ^ 3'd1);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] y,
                                                  logic [COORD_W-1:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [ADDR_W-1:0] nbr_addr(logic [COORD_W-1:0] x,
                                                 logic [COORD_W-1:0] y,
                                                 logic [COORD_W-1:0] z,
                                                 logic [NBR_W-1:0]   k);
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic [COORD_W-1:0] nz;
    nx = x;
    ny = y;
    nz = z;
    case (k)
      3'd0:    nx = x - 5'd1;
      3'd1:    nx = x + 5'd1;
      3'd2:    ny = y - 5'd1;
      3'd3:    ny = y + 5'd1;
      3'd4:    nz = z - 5'd1;
      3'd5:    nz = z + 5'd1;
      default: nx = x;
    endcase
    return cell_addr(nx, ny, nz);
  endfunction

endpackage

@@ rtl/vefm_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
module vefm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/vefm_front.sv @@
// Front end: size registers, range and neighbor classification, two-entry command queue.
module vefm_front import vefm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  vefm_in_t             cmd_i,
  input  logic                 hold_i,
  output logic                 busy_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SIZE_W-1:0]    cfg_data_i,
  output logic                 q_valid_o,
  output vefm_cmd_t            q_item_o,
  input  logic                 q_pop_i
);

  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [SIZE_W-1:0] lim_x, lim_y, lim_z;
  logic [SIZE_W-1:0] ext_x, ext_y, ext_z;
  vefm_cmd_t         cls;
  vefm_cmd_t         q_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;
  logic              push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_RESET;
      size_y_q <= SIZE_RESET;
      size_z_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SIZE_X: size_x_q <= cfg_data_i;
        CFG_SIZE_Y: size_y_q <= cfg_data_i;
        CFG_SIZE_Z: size_z_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  always_comb begin
    lim_x = (size_x_q < SIZE_W'(MAX_X)) ? size_x_q : SIZE_W'(MAX_X);
    lim_y = (size_y_q < SIZE_W'(MAX_Y)) ? size_y_q : SIZE_W'(MAX_Y);
    lim_z = (size_z_q < SIZE_W'(MAX_Z)) ? size_z_q : SIZE_W'(MAX_Z);
    ext_x = {1'b0, cmd_i.x_coord};
    ext_y = {1'b0, cmd_i.y_coord};
    ext_z = {1'b0, cmd_i.z_coord};
    cls.func      = cmd_i.func;
    cls.x         = cmd_i.x_coord;
    cls.y         = cmd_i.y_coord;
    cls.z         = cmd_i.z_coord;
    cls.in_range  = (ext_x < lim_x) && (ext_y < lim_y) && (ext_z < lim_z);
    cls.nbr_ok[0] = (cmd_i.x_coord != '0);
    cls.nbr_ok[1] = ((ext_x + 6'd1) < lim_x);
    cls.nbr_ok[2] = (cmd_i.y_coord != '0);
    cls.nbr_ok[3] = ((ext_y + 6'd1) < lim_y);
    cls.nbr_ok[4] = (cmd_i.z_coord != '0);
    cls.nbr_ok[5] = ((ext_z + 6'd1) < lim_z);
  end

  assign busy_o = hold_i || (cnt_q == 2'd2);
  assign push   = start_i && !busy_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = q_q[rd_ptr_q];

endmodule

@@ rtl/vefm_back.sv @@
// Back end: clearing pass, neighbor read-modify-write sequencer and query path.
module vefm_back import vefm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  vefm_cmd_t q_item_i,
  output logic      q_pop_o,
  output logic      clearing_o,
  output logic      res_strobe_o,
  output vefm_out_t res_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_INS   = 3'd2;
  localparam logic [2:0] ST_SELF  = 3'd3;
  localparam logic [2:0] ST_QRD   = 3'd4;
  localparam logic [2:0] ST_QRSP  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  vefm_cmd_t         cur_q, cur_d;
  logic [NBR_W-1:0]  k_q, k_d;
  logic [NBR_W-1:0]  kd_q, kd_d;
  logic              rd_vld_q, rd_vld_d;
  logic [ADDR_W-1:0] ra_q, ra_d;
  logic [FACE_W-1:0] mask_q, mask_d;
  logic              strobe_q, strobe_d;
  vefm_out_t         res_q, res_d;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata;

  vefm_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    cur_d    = cur_q;
    k_d      = k_q;
    kd_d     = kd_q;
    rd_vld_d = 1'b0;
    ra_d     = ra_q;
    mask_d   = mask_q;
    strobe_d = 1'b0;
    res_d    = res_q;
    we       = 1'b0;
    waddr    = clr_q;
    wdata    = '0;
    re       = 1'b0;
    raddr    = ra_q;
    q_pop_o  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_item_i;
          if (!q_item_i.in_range) begin
            strobe_d = 1'b1;
            res_d    = '0;
          end else if (q_item_i.func == FUNC_INSERT) begin
            k_d     = '0;
            mask_d  = ALL_FACES;
            state_d = ST_INS;
          end else begin
            state_d = ST_QRD;
          end
        end
      end
      ST_INS: begin
        if (k_q < NBR_W'(NUM_NBR)) begin
          re       = 1'b1;
          raddr    = nbr_addr(cur_q.x, cur_q.y, cur_q.z, k_q);
          ra_d     = raddr;
          kd_d     = k_q;
          rd_vld_d = 1'b1;
          k_d      = k_q + NBR_W'(1);
        end else begin
          state_d = ST_SELF;
        end
        if (rd_vld_q && rdata[FACE_W] && cur_q.nbr_ok[kd_q]) begin
          mask_d = mask_q & ~own_bit(kd_q);
          we     = 1'b1;
          waddr  = ra_q;
          wdata  = {1'b1, rdata[FACE_W-1:0] & ~their_bit(kd_q)};
        end
      end
      ST_SELF: begin
        we                 = 1'b1;
        waddr              = cell_addr(cur_q.x, cur_q.y, cur_q.z);
        wdata              = {1'b1, mask_q};
        strobe_d           = 1'b1;
        res_d.in_range     = 1'b1;
        res_d.occupied     = 1'b1;
        res_d.face_mask    = mask_q;
        res_d.visible      = (mask_q != '0);
        state_d            = ST_IDLE;
      end
      ST_QRD: begin
        re      = 1'b1;
        raddr   = cell_addr(cur_q.x, cur_q.y, cur_q.z);
        state_d = ST_QRSP;
      end
      ST_QRSP: begin
        strobe_d        = 1'b1;
        res_d.in_range  = 1'b1;
        res_d.occupied  = rdata[FACE_W];
        res_d.face_mask = rdata[FACE_W] ? rdata[FACE_W-1:0] : '0;
        res_d.visible   = rdata[FACE_W] && (rdata[FACE_W-1:0] != '0);
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      rd_vld_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      rd_vld_q <= rd_vld_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    k_q    <= k_d;
    kd_q   <= kd_d;
    ra_q   <= ra_d;
    mask_q <= mask_d;
    res_q  <= res_d;
  end

  assign clearing_o   = (state_q == ST_CLEAR);
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

@@ rtl/voxel_exposed_face_mask.sv @@
// Top level of the voxel exposed face mask block.
//
// Commands: drive cmd_i and raise start; a beat is taken at a clock edge with
// start high and busy low. func selects insert or query of one voxel.
// Results: one beat per command, in command order, on res_o for one cycle
// with res_strobe_o high. There is no back pressure on results.
// Config: cfg_valid_i/cfg_ready_o write size_x, size_y, size_z by index;
// ready is always high. Write sizes only while the block is idle.
// Sequence in the back end once it takes a command from the queue: an
// out-of-range command is answered at once, a query reads the cell, an insert
// reads and writes back the six neighbors through the one-read one-write cell
// RAM, then writes the cell. The result appears the cycle after the last step.
// A two-beat command queue lets start be taken while the back end works.
// Reset: sizes return to 32 and the cell RAM is swept to empty, one cell a
// cycle over all 32768 cells; busy stays high during the sweep.
module voxel_exposed_face_mask import vefm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  vefm_in_t             cmd_i,
  output logic                 res_strobe_o,
  output vefm_out_t            res_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SIZE_W-1:0]    cfg_data_i
);

  logic      clearing;
  logic      q_valid;
  logic      q_pop;
  vefm_cmd_t q_item;

  assign cfg_ready_o = 1'b1;

  vefm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd_i),
    .hold_i      (clearing),
    .busy_o      (busy),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  vefm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .clearing_o   (clearing),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule

@@ sim/tb_top.sv @@
// Testbench for voxel_exposed_face_mask: queued commands against a grid predictor.
`timescale 1ns / 100ps

module tb_top;
  import vefm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  vefm_in_t             cmd_i = '0;
  logic                 res_strobe_o;
  vefm_out_t            res_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [SIZE_W-1:0]    cfg_data_i = '0;

  voxel_exposed_face_mask dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  vefm_in_t  voxel_cmds [$];
  vefm_out_t voxel_answers [$];

  bit                occ_map  [CELLS];
  bit [FACE_W-1:0]   face_map [CELLS];
  logic [SIZE_W-1:0] size_x_q = SIZE_RESET;
  logic [SIZE_W-1:0] size_y_q = SIZE_RESET;
  logic [SIZE_W-1:0] size_z_q = SIZE_RESET;

  int cycle_cnt = 0;
  int err_cnt   = 0;
  bit took_beat = 1'b0;
  bit gaps_on   = 1'b1;
  int gap_left  = 0;

  function automatic int grid_lim(logic [SIZE_W-1:0] s, int mx);
    return (int'(s) < mx) ? int'(s) : mx;
  endfunction

  function automatic vefm_out_t grid_apply(vefm_in_t c);
    vefm_out_t         r;
    int                lx, ly, lz;
    int                nx, ny, nz;
    int                self_i, nbr_i;
    logic [FACE_W-1:0] mask, own, their;
    r  = '0;
    lx = grid_lim(size_x_q, int'(MAX_X));
    ly = grid_lim(size_y_q, int'(MAX_Y));
    lz = grid_lim(size_z_q, int'(MAX_Z));
    if (int'(c.x_coord) < lx && int'(c.y_coord) < ly && int'(c.z_coord) < lz) begin
      r.in_range = 1'b1;
      self_i = int'(c.x_coord) +
               int'(MAX_X) * (int'(c.y_coord) + int'(MAX_Y) * int'(c.z_coord));
      if (c.func == FUNC_INSERT) begin
        mask = ALL_FACES;
        for (int k = 0; k < NUM_NBR; k++) begin
          nx = int'(c.x_coord);
          ny = int'(c.y_coord);
          nz = int'(c.z_coord);
          case (k)
            0: nx = nx - 1;
            1: nx = nx + 1;
            2: ny = ny - 1;
            3: ny = ny + 1;
            4: nz = nz - 1;
            default: nz = nz + 1;
          endcase
          own   = 6'b100000 >> k;
          their = (k % 2 == 0) ? (own >> 1) : (own << 1);
          if (nx >= 0 && ny >= 0 && nz >= 0 && nx < lx && ny < ly && nz < lz) begin
            nbr_i = nx + int'(MAX_X) * (ny + int'(MAX_Y) * nz);
            if (occ_map[nbr_i]) begin
              mask = mask & ~own;
              face_map[nbr_i] = face_map[nbr_i] & ~their;
            end
          end
        end
        occ_map[self_i]  = 1'b1;
        face_map[self_i] = mask;
        r.occupied  = 1'b1;
        r.face_mask = mask;
      end else begin
        r.occupied  = occ_map[self_i];
        r.face_mask = occ_map[self_i] ? face_map[self_i] : '0;
      end
      r.visible = r.occupied && (r.face_mask != '0);
    end
    return r;
  endfunction

  task automatic note_mismatch(string what);
    $display("tb_top: mismatch at cycle %0d: %s", cycle_cnt, what);
    err_cnt++;
  endtask

  // monitor: results first, then the command beat and config beat of this edge
  always @(posedge clk_i) begin
    vefm_out_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else if (rst_ni) begin
      if (res_strobe_o) begin
        if (voxel_answers.size() == 0) begin
          note_mismatch($sformatf("result %0h with nothing pending", res_o));
        end else begin
          want = voxel_answers.pop_front();
          if (res_o.in_range !== want.in_range)
            note_mismatch($sformatf("in_range %0h want %0h", res_o.in_range, want.in_range));
          if (res_o.occupied !== want.occupied)
            note_mismatch($sformatf("occupied %0h want %0h", res_o.occupied, want.occupied));
          if (res_o.face_mask !== want.face_mask)
            note_mismatch($sformatf("face_mask %0h want %0h", res_o.face_mask,
                                    want.face_mask));
          if (res_o.visible !== want.visible)
            note_mismatch($sformatf("visible %0h want %0h", res_o.visible, want.visible));
        end
      end
      took_beat = start && !busy;
      if (took_beat) voxel_answers = {voxel_answers, grid_apply(cmd_i)};
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SIZE_X: size_x_q = cfg_data_i;
          CFG_SIZE_Y: size_y_q = cfg_data_i;
          CFG_SIZE_Z: size_z_q = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // driver: one command beat at a time, with random gap bursts while gaps_on is set
  always @(negedge clk_i) begin
    if (start && !took_beat) begin
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (voxel_cmds.size() == 0) begin
      start <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      gap_left = $urandom_range(0, 18);
      start <= 1'b0;
    end else begin
      cmd_i <= voxel_cmds.pop_front();
      start <= 1'b1;
    end
  end

  task automatic push_cmd(logic func, int x, int y, int z);
    vefm_in_t c;
    c.func    = func;
    c.x_coord = x[COORD_W-1:0];
    c.y_coord = y[COORD_W-1:0];
    c.z_coord = z[COORD_W-1:0];
    voxel_cmds = {voxel_cmds, c};
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (voxel_cmds.size() != 0 || start || voxel_answers.size() != 0 || busy);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[SIZE_W-1:0];
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_grid(int sx, int sy, int sz);
    write_reg(CFG_SIZE_X, sx);
    write_reg(CFG_SIZE_Y, sy);
    write_reg(CFG_SIZE_Z, sz);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord(int lim, int ctr);
    int v;
    int pick;
    pick = $urandom_range(0, 9);
    if (lim == 0 || pick == 0) begin
      v = $urandom_range(0, 31);
    end else if (pick < 5) begin
      v = $urandom_range(0, lim - 1);
    end else begin
      v = ctr + int'($urandom_range(0, 2)) - 1;
      if (v < 0) v = 0;
      if (v > lim - 1) v = lim - 1;
    end
    return v[COORD_W-1:0];
  endfunction

  initial begin : stimulus
    int ph_x [8] = '{32, 8, 63, 1, 17, 0, 0, 32};
    int ph_y [8] = '{32, 4, 63, 32, 9, 5, 0, 32};
    int ph_z [8] = '{32, 2, 63, 1, 31, 5, 0, 32};
    int ph_n [8] = '{300, 250, 250, 150, 250, 50, 250, 300};
    int sx, sy, sz, lx, ly, lz, cx, cy, cz;
    logic func;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    wait_quiet();

    set_grid(32, 32, 32);
    push_cmd(FUNC_QUERY, 0, 0, 0);
    push_cmd(FUNC_INSERT, 0, 0, 0);
    push_cmd(FUNC_QUERY, 0, 0, 0);
    push_cmd(FUNC_INSERT, 1, 0, 0);
    push_cmd(FUNC_INSERT, 1, 0, 0);
    push_cmd(FUNC_QUERY, 0, 0, 0);
    push_cmd(FUNC_INSERT, 31, 31, 31);
    push_cmd(FUNC_INSERT, 30, 31, 31);
    push_cmd(FUNC_QUERY, 31, 31, 31);
    // fully enclosed cell
    push_cmd(FUNC_INSERT, 9, 10, 10);
    push_cmd(FUNC_INSERT, 11, 10, 10);
    push_cmd(FUNC_INSERT, 10, 9, 10);
    push_cmd(FUNC_INSERT, 10, 11, 10);
    push_cmd(FUNC_INSERT, 10, 10, 9);
    push_cmd(FUNC_INSERT, 10, 10, 11);
    push_cmd(FUNC_INSERT, 10, 10, 10);
    push_cmd(FUNC_QUERY, 10, 10, 10);
    push_cmd(FUNC_INSERT, 16, 3, 3);
    wait_quiet();

    // stale neighbor beyond a shrunk x size must not count
    set_grid(16, 32, 32);
    push_cmd(FUNC_INSERT, 15, 3, 3);
    push_cmd(FUNC_QUERY, 16, 3, 3);
    push_cmd(FUNC_QUERY, 15, 3, 3);
    wait_quiet();

    set_grid(1, 1, 1);
    push_cmd(FUNC_INSERT, 0, 0, 0);
    push_cmd(FUNC_INSERT, 0, 1, 0);
    wait_quiet();

    set_grid(0, 63, 63);
    push_cmd(FUNC_INSERT, 0, 0, 0);
    push_cmd(FUNC_QUERY, 31, 31, 31);
    wait_quiet();

    for (int p = 0; p < 8; p++) begin
      sx = ph_x[p];
      sy = ph_y[p];
      sz = ph_z[p];
      if (p == 6) begin
        sx = $urandom_range(1, 32);
        sy = $urandom_range(1, 32);
        sz = $urandom_range(1, 32);
      end
      gaps_on = (p != 7);
      set_grid(sx, sy, sz);
      lx = (sx < 32) ? sx : 32;
      ly = (sy < 32) ? sy : 32;
      lz = (sz < 32) ? sz : 32;
      cx = 0;
      cy = 0;
      cz = 0;
      for (int i = 0; i < ph_n[p]; i++) begin
        if (i % 24 == 0) begin
          cx = (lx > 0) ? $urandom_range(0, lx - 1) : 0;
          cy = (ly > 0) ? $urandom_range(0, ly - 1) : 0;
          cz = (lz > 0) ? $urandom_range(0, lz - 1) : 0;
        end
        func = ($urandom_range(0, 99) < 55) ? FUNC_INSERT : FUNC_QUERY;
        push_cmd(func, rand_coord(lx, cx), rand_coord(ly, cy), rand_coord(lz, cz));
      end
      wait_quiet();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
